[design/packet_id_gap_tracker_unit_assert.svh]
// assertion macros used by the packet id gap tracker back end
`ifndef PACKET_ID_GAP_TRACKER_UNIT_ASSERT_SVH
`define PACKET_ID_GAP_TRACKER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define PGT_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("pgt assertion failed");
// cause in one cycle, effect in the next
`define PGT_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("pgt assertion failed");
`else
`define PGT_ASSERT(lbl, ck, rn, prop)
`define PGT_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

[design/pgt_pkg.sv]
// shared types, constants and codes of the packet id gap tracker
package pgt_pkg;

  localparam int ID_SPACE_DEF = 256;
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 9;
  localparam int SCAN_W       = 32;
  localparam int LOG_W        = $clog2(SCAN_W);
  localparam int RANGE_MIN    = 3;
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic [BYTE_W-1:0] MASK_RESET = 8'd63;

  localparam logic REQ_RECORD  = 1'b0;
  localparam logic REQ_REPORT  = 1'b1;
  localparam logic CLS_CONTROL = 1'b0;
  localparam logic CLS_DATA    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic              packet_class;
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] packet_id;
    logic [POS_W-1:0]  start_index;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_length;
    logic              gap_found;
    logic [BYTE_W-1:0] gap_low;
    logic [BYTE_W-1:0] gap_high;
    logic [POS_W-1:0]  resume_index;
    logic [BYTE_W-1:0] largest_payload;
    logic [BYTE_W-1:0] highest_seen;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ZERO,
    BK_ONE
  } bk_state_t;

endpackage

[design/packet_id_gap_tracker_unit.sv]
// path: a record goes through the front queue and the back end into the result queue, both queues registered
// path: a report starting below the highest id also scans the bitmap one 32-id chunk per cycle
// throughput: one record per cycle unless the result queue is full or a report scan is running
// the chunk scanner in the back end sets the report rate
// reset: bitmaps, payload maximum, highest ids and queues clear at once, mask goes to 63
module packet_id_gap_tracker_unit #(
  parameter int ID_SPACE = pgt_pkg::ID_SPACE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       push,
  output logic                       full,
  input  logic                       in_req_type,
  input  logic                       in_packet_class,
  input  logic [pgt_pkg::BYTE_W-1:0] in_header_byte,
  input  logic [pgt_pkg::BYTE_W-1:0] in_packet_id,
  input  logic [pgt_pkg::POS_W-1:0]  in_start_index,
  // result channel
  output logic                       empty,
  input  logic                       pop,
  output logic [pgt_pkg::BYTE_W-1:0] out_payload_length,
  output logic                       out_gap_found,
  output logic [pgt_pkg::BYTE_W-1:0] out_gap_low,
  output logic [pgt_pkg::BYTE_W-1:0] out_gap_high,
  output logic [pgt_pkg::POS_W-1:0]  out_resume_index,
  output logic [pgt_pkg::BYTE_W-1:0] out_largest_payload,
  output logic [pgt_pkg::BYTE_W-1:0] out_highest_seen,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pgt_pkg::BYTE_W-1:0] cfg_payload_mask
);
  import pgt_pkg::*;

  cmd_t cmd;
  res_t res_in, res_out;
  logic cmd_valid, cmd_pop;
  logic res_push, res_full;

  // mask register lives in the back end and takes a write every cycle
  assign cfg_ready = 1'b1;

  // front: classify requests and buffer them
  pgt_front #(
    .ID_SPACE (ID_SPACE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .req_type     (in_req_type),
    .packet_class (in_packet_class),
    .header_byte  (in_header_byte),
    .packet_id    (in_packet_id),
    .start_index  (in_start_index),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back: records update the maps directly, reports walk the bitmap a chunk per cycle
  pgt_back #(
    .ID_SPACE (ID_SPACE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_mask  (cfg_payload_mask),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // results wait here so the back end keeps going while the consumer stalls, until the queue fills
  pgt_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  // oldest waiting transaction onto the result ports
  assign out_payload_length  = res_out.payload_length;
  assign out_gap_found       = res_out.gap_found;
  assign out_gap_low         = res_out.gap_low;
  assign out_gap_high        = res_out.gap_high;
  assign out_resume_index    = res_out.resume_index;
  assign out_largest_payload = res_out.largest_payload;
  assign out_highest_seen    = res_out.highest_seen;

endmodule

[design/pgt_front.sv]
// front end: classifies incoming requests and queues them for the back end
module pgt_front #(
  parameter int ID_SPACE = pgt_pkg::ID_SPACE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      req_type,
  input  logic                      packet_class,
  input  logic [pgt_pkg::BYTE_W-1:0] header_byte,
  input  logic [pgt_pkg::BYTE_W-1:0] packet_id,
  input  logic [pgt_pkg::POS_W-1:0]  start_index,
  output logic                      cmd_valid,
  output pgt_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import pgt_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  cmd_t            cmd_in;
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            wr, rd;

  // ids outside the map are flagged here so the back end skips the bitmap
  always_comb begin
    cmd_in.req_type     = req_type;
    cmd_in.packet_class = packet_class;
    cmd_in.header_byte  = header_byte;
    cmd_in.packet_id    = packet_id;
    cmd_in.start_index  = start_index;
    cmd_in.in_range     = (int'(packet_id) < ID_SPACE);
  end

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = slot_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule

[design/pgt_back.sv]
// back end: bitmaps, payload maximum and chunked gap scanner
`include "packet_id_gap_tracker_unit_assert.svh"
module pgt_back #(
  parameter int ID_SPACE = pgt_pkg::ID_SPACE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pgt_pkg::BYTE_W-1:0] cfg_mask,
  input  logic                       cmd_valid,
  input  pgt_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output pgt_pkg::res_t              res
);
  import pgt_pkg::*;

  localparam int IDX_W = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;

  logic [ID_SPACE-1:0] ctrl_map_r, data_map_r, scan_map;
  logic [BYTE_W-1:0]   max_r, max_nxt, mask_r;
  logic [BYTE_W-1:0]   ctrl_hi_r, data_hi_r, sel_hi, new_hi, hi_r, hi_nxt;
  bk_state_t           state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt, zlo_r, zlo_nxt;
  logic                cls_r, cls_nxt;
  logic                rec_we;
  logic [BYTE_W-1:0]   plen;
  logic [POS_W-1:0]    base, cand, hi_ext, gap_len, cand_m1, zlo_p1;
  logic [POS_W:0]      next_base;
  logic [SCAN_W-1:0]   chunk, keep, srch;
  logic [LOG_W:0]      hit_enc;
  logic                hit;
  logic [IDX_W-1:0]    pid_idx;

  // reads one scan chunk; positions past the map read as unseen
  function automatic logic [SCAN_W-1:0] get_chunk(input logic [ID_SPACE-1:0] m,
                                                   input logic [POS_W-1:0] b0);
    int unsigned       idx;
    logic [SCAN_W-1:0] v;
    v = '0;
    for (int b = 0; b < SCAN_W; b++) begin
      idx = int'(b0) + b;
      if (idx < ID_SPACE) begin
        v[b] = m[IDX_W'(idx)];
      end
    end
    return v;
  endfunction

  // lowest set bit, msb of the result flags a hit
  function automatic logic [LOG_W:0] first_hit(input logic [SCAN_W-1:0] v);
    logic [LOG_W:0] r;
    r = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = {1'b1, LOG_W'(b)};
      end
    end
    return r;
  endfunction

  // record path
  assign sel_hi  = (cmd.packet_class == CLS_DATA) ? data_hi_r : ctrl_hi_r;
  assign plen    = (cmd.packet_class == CLS_DATA) ? (cmd.header_byte & mask_r) : '0;
  assign max_nxt = (plen > max_r) ? plen : max_r;
  assign new_hi  = (cmd.in_range && (cmd.packet_id > sel_hi)) ? cmd.packet_id : sel_hi;
  assign pid_idx = IDX_W'(cmd.packet_id);

  // scan path
  assign scan_map  = cls_r ? data_map_r : ctrl_map_r;
  assign base      = {pos_r[POS_W-1:LOG_W], {LOG_W{1'b0}}};
  assign chunk     = get_chunk(scan_map, base);
  assign keep      = {SCAN_W{1'b1}} << pos_r[LOG_W-1:0];
  assign srch      = (state_r == BK_ZERO) ? (~chunk & keep) : (chunk & keep);
  assign hit_enc   = first_hit(srch);
  assign hit       = hit_enc[LOG_W];
  assign cand      = base + POS_W'(hit_enc[LOG_W-1:0]);
  assign next_base = {1'b0, base} + (POS_W+1)'(SCAN_W);
  assign hi_ext    = POS_W'(hi_r);
  assign gap_len   = cand - zlo_r;
  assign cand_m1   = cand - POS_W'(1);
  assign zlo_p1    = zlo_r + POS_W'(1);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    zlo_nxt   = zlo_r;
    cls_nxt   = cls_r;
    hi_nxt    = hi_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    rec_we    = 1'b0;
    res       = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.req_type == REQ_RECORD) begin
            rec_we                = 1'b1;
            res_push              = 1'b1;
            res.payload_length    = plen;
            res.largest_payload   = max_nxt;
            res.highest_seen      = new_hi;
          end else if (POS_W'(sel_hi) > cmd.start_index) begin
            state_nxt = BK_ZERO;
            pos_nxt   = cmd.start_index;
            cls_nxt   = cmd.packet_class;
            hi_nxt    = sel_hi;
          end else begin
            res_push            = 1'b1;
            res.resume_index    = cmd.start_index;
            res.largest_payload = max_r;
            res.highest_seen    = sel_hi;
          end
        end
      end
      BK_ZERO: begin
        if (hit && (cand < hi_ext)) begin
          zlo_nxt   = cand;
          pos_nxt   = cand + POS_W'(1);
          state_nxt = BK_ONE;
        end else if (next_base > {1'b0, hi_ext}) begin
          res_push            = 1'b1;
          res.resume_index    = hi_ext;
          res.largest_payload = max_r;
          res.highest_seen    = hi_r;
          state_nxt           = BK_IDLE;
        end else begin
          pos_nxt = next_base[POS_W-1:0];
        end
      end
      BK_ONE: begin
        if (hit) begin
          res_push            = 1'b1;
          res.gap_found       = 1'b1;
          res.gap_low         = zlo_r[BYTE_W-1:0];
          res.largest_payload = max_r;
          res.highest_seen    = hi_r;
          if (gap_len >= POS_W'(RANGE_MIN)) begin
            res.gap_high     = cand_m1[BYTE_W-1:0];
            res.resume_index = cand;
          end else begin
            res.gap_high     = zlo_r[BYTE_W-1:0];
            res.resume_index = zlo_p1;
          end
          state_nxt = BK_IDLE;
        end else begin
          pos_nxt = next_base[POS_W-1:0];
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      ctrl_map_r <= '0;
      data_map_r <= '0;
      max_r      <= '0;
      ctrl_hi_r  <= '0;
      data_hi_r  <= '0;
      mask_r     <= MASK_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mask_r <= cfg_mask;
      end
      if (rec_we) begin
        max_r <= max_nxt;
        if (cmd.packet_class == CLS_CONTROL) begin
          ctrl_hi_r <= new_hi;
          if (cmd.in_range) begin
            ctrl_map_r[pid_idx] <= 1'b1;
          end
        end else begin
          data_hi_r <= new_hi;
          if (cmd.in_range) begin
            data_map_r[pid_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    zlo_r <= zlo_nxt;
    cls_r <= cls_nxt;
    hi_r  <= hi_nxt;
  end

  `PGT_ASSERT(a_no_res_overflow, clk, rst_n, !(res_push && res_full))
  `PGT_ASSERT(a_no_pop_mid_scan, clk, rst_n, !((state_r != BK_IDLE) && cmd_pop))
  `PGT_ASSERT(a_gap_below_high, clk, rst_n, !((state_r == BK_ONE) && (zlo_r >= hi_ext)))
  `PGT_ASSERT(a_zero_scan_bound, clk, rst_n, !((state_r == BK_ZERO) && (pos_r > hi_ext)))
  `PGT_ASSERT_NEXT(a_max_monotonic, clk, rst_n, 1'b1, max_r >= $past(max_r))

endmodule

[design/pgt_res_fifo.sv]
// result queue between the back end and the output ports
module pgt_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  pgt_pkg::res_t res_in,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output pgt_pkg::res_t res_out
);
  import pgt_pkg::*;

  res_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            rd;

  assign res_full = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign res_out  = slot_r[rp_r];
  assign rd       = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !res_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot_r[wp_r] <= res_in;
    end
  end

endmodule

[tb/packet_id_gap_tracker_unit_tb.sv]
// testbench for the packet id gap tracker: queued requests, predicted results, random idling
`timescale 1ns / 100ps

module packet_id_gap_tracker_unit_tb;
  import pgt_pkg::*;

  localparam int IDS        = ID_SPACE_DEF;
  localparam int SETTLE     = 16;    // settle time after each drain
  localparam int IDLE_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int PHASE_REQS = 166;

  // one request as queued for the driver
  typedef struct {
    logic              req_type;
    logic              packet_class;
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] packet_id;
    logic [POS_W-1:0]  start_index;
    bit                chained;  // start where the last report of this class left off
  } tracker_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              push = 1'b0;
  logic              full;
  logic              in_req_type = REQ_RECORD;
  logic              in_packet_class = CLS_CONTROL;
  logic [BYTE_W-1:0] in_header_byte = '0;
  logic [BYTE_W-1:0] in_packet_id = '0;
  logic [POS_W-1:0]  in_start_index = '0;

  logic              empty;
  logic              pop = 1'b0;
  logic [BYTE_W-1:0] out_payload_length;
  logic              out_gap_found;
  logic [BYTE_W-1:0] out_gap_low;
  logic [BYTE_W-1:0] out_gap_high;
  logic [POS_W-1:0]  out_resume_index;
  logic [BYTE_W-1:0] out_largest_payload;
  logic [BYTE_W-1:0] out_highest_seen;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BYTE_W-1:0] cfg_payload_mask = MASK_RESET;

  packet_id_gap_tracker_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_req_type        (in_req_type),
    .in_packet_class    (in_packet_class),
    .in_header_byte     (in_header_byte),
    .in_packet_id       (in_packet_id),
    .in_start_index     (in_start_index),
    .empty              (empty),
    .pop                (pop),
    .out_payload_length (out_payload_length),
    .out_gap_found      (out_gap_found),
    .out_gap_low        (out_gap_low),
    .out_gap_high       (out_gap_high),
    .out_resume_index   (out_resume_index),
    .out_largest_payload(out_largest_payload),
    .out_highest_seen   (out_highest_seen),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_payload_mask   (cfg_payload_mask)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the tracker state
  bit   [IDS-1:0]    seen_ctrl = '0;
  bit   [IDS-1:0]    seen_data = '0;
  logic [BYTE_W-1:0] longest_payload = '0;
  logic [BYTE_W-1:0] length_mask = MASK_RESET;

  tracker_req_t  pending_reqs[$];
  res_t          tracked_results[$];
  logic [POS_W-1:0] last_resume[2] = '{default: '0};

  int  issued = 0;     // requests handed to the port
  int  returned = 0;   // results taken off the port
  int  failures = 0;
  bit  calm = 1'b0;    // no idling on either side

  // applies one request to the shadow state and works out its result
  function automatic res_t track_request(input tracker_req_t rq);
    res_t          r;
    bit [IDS-1:0]  seen;
    int            top;
    int            i;
    r = '0;
    seen = (rq.packet_class == CLS_DATA) ? seen_data : seen_ctrl;
    if (rq.req_type == REQ_RECORD) begin
      if (rq.packet_id < IDS) seen[rq.packet_id] = 1'b1;
      if (rq.packet_class == CLS_DATA) begin
        r.payload_length = rq.header_byte & length_mask;
        if (r.payload_length > longest_payload) longest_payload = r.payload_length;
        seen_data = seen;
      end else begin
        seen_ctrl = seen;
      end
    end
    // id 0 never counts as the highest seen
    top = IDS - 1;
    while (top > 0 && !seen[top]) top--;
    if (rq.req_type == REQ_REPORT) begin
      i = rq.start_index;
      // indexes read never pass top, which is seen, so the scans stop
      while (i < top) begin
        if (!seen[i] && !seen[i+1] && !seen[i+2]) begin
          r.gap_low = 8'(i);
          i += RANGE_MIN;
          while (!seen[i]) i++;
          r.gap_high = 8'(i - 1);
          r.gap_found = 1'b1;
          break;
        end else if (!seen[i]) begin
          r.gap_low = 8'(i);
          r.gap_high = 8'(i);
          i++;
          r.gap_found = 1'b1;
          break;
        end else begin
          i++;
        end
      end
      r.resume_index = POS_W'(i);
    end
    r.largest_payload = longest_payload;
    r.highest_seen = 8'(top);
    return r;
  endfunction

  task automatic queue_req(input logic rt, input logic pc, input logic [BYTE_W-1:0] hb,
                           input logic [BYTE_W-1:0] pid, input logic [POS_W-1:0] si);
    tracker_req_t rq;
    rq = '{rt, pc, hb, pid, si, 1'b0};
    pending_reqs.push_back(rq);
  endtask

  // random requests: records mostly land in the low half of each 8-id block so
  // the upper half stays open as ranges, half of the reports walk the gaps in order
  task automatic queue_random(input int count);
    tracker_req_t rq;
    int           pick;
    repeat (count) begin
      rq.req_type = ($urandom_range(0, 99) < 45) ? REQ_RECORD : REQ_REPORT;
      rq.packet_class = $urandom_range(0, 1) ? CLS_DATA : CLS_CONTROL;
      rq.header_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0)
        rq.packet_id = 8'($urandom_range(0, 255));
      else
        rq.packet_id = 8'($urandom_range(0, 31) * 8 + $urandom_range(0, 3));
      rq.chained = 1'b0;
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: begin
          rq.chained = 1'b1;
          rq.start_index = '0;
        end
        5, 6: rq.start_index = POS_W'($urandom_range(0, IDS));
        7:    rq.start_index = '0;
        8:    rq.start_index = POS_W'(IDS);
        default: rq.start_index = POS_W'($urandom_range(IDS - 56, IDS));
      endcase
      pending_reqs.push_back(rq);
    end
  endtask

  // waits until every queued request has come back, then lets the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || issued != returned) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(input logic [BYTE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_payload_mask <= value;
    do @(posedge clk); while (!cfg_ready);
    length_mask = value;
    cfg_valid <= 1'b0;
  endtask

  // driver: presents the next pending request, with random idle bursts
  tracker_req_t on_port;
  tracker_req_t next_req;
  res_t         outcome;
  int           gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      // prediction happens at the accepting edge, in order of acceptance
      if (push && !full) begin
        outcome = track_request(on_port);
        tracked_results.push_back(outcome);
        if (on_port.req_type == REQ_REPORT)
          last_resume[on_port.packet_class] = outcome.resume_index;
      end
      if (push && full) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        if (next_req.chained)
          next_req.start_index = last_resume[next_req.packet_class];
        on_port = next_req;
        issued++;
        in_req_type <= next_req.req_type;
        in_packet_class <= next_req.packet_class;
        in_header_byte <= next_req.header_byte;
        in_packet_id <= next_req.packet_id;
        in_start_index <= next_req.start_index;
        push <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 18);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes results with random stall bursts and checks them in order
  res_t seen_res;
  res_t want;
  int   stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        returned++;
        seen_res = '{out_payload_length, out_gap_found, out_gap_low, out_gap_high,
                     out_resume_index, out_largest_payload, out_highest_seen};
        if (tracked_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("result transaction with nothing expected at %0t", $realtime);
        end else begin
          want = tracked_results.pop_front();
          if (seen_res !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch at %0t (len found low high resume max top)", $realtime);
              $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.payload_length,
                       want.gap_found, want.gap_low, want.gap_high, want.resume_index,
                       want.largest_payload, want.highest_seen);
              $display("  actual   %0d %0d %0d %0d %0d %0d %0d", seen_res.payload_length,
                       seen_res.gap_found, seen_res.gap_low, seen_res.gap_high,
                       seen_res.resume_index, seen_res.largest_payload,
                       seen_res.highest_seen);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // watchdog: ends the run when no transaction of any kind happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** packet_id_gap_tracker_unit: FAILED **");
    $finish;
  end

  initial begin : sequencer
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, mask still at its reset value
    queue_req(REQ_REPORT, CLS_CONTROL, 8'h00, 8'h00, 9'd0);     // nothing seen yet
    queue_req(REQ_REPORT, CLS_DATA,    8'hFF, 8'hFF, 9'd256);
    queue_req(REQ_RECORD, CLS_CONTROL, 8'hFF, 8'h00, 9'd0);     // control record, id 0
    queue_req(REQ_REPORT, CLS_CONTROL, 8'h00, 8'h00, 9'd0);     // id 0 alone is not highest
    queue_req(REQ_RECORD, CLS_DATA,    8'hFF, 8'hFF, 9'd0);     // largest id and header
    queue_req(REQ_RECORD, CLS_DATA,    8'h00, 8'h00, 9'd0);
    queue_req(REQ_RECORD, CLS_DATA,    8'hAA, 8'h01, 9'd0);
    queue_req(REQ_RECORD, CLS_DATA,    8'h55, 8'h05, 9'd0);
    queue_req(REQ_RECORD, CLS_DATA,    8'h1C, 8'h07, 9'd0);
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd0);     // range 2..4
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd5);     // single 6
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd7);     // long range up to 254
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd255);   // start at the highest
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd256);   // start above the highest
    queue_req(REQ_RECORD, CLS_CONTROL, 8'h55, 8'hFF, 9'd0);
    queue_req(REQ_RECORD, CLS_CONTROL, 8'h55, 8'h80, 9'd0);
    queue_req(REQ_REPORT, CLS_CONTROL, 8'h00, 8'h00, 9'd1);     // range 1..127
    queue_req(REQ_REPORT, CLS_CONTROL, 8'h00, 8'h00, 9'd200);
    queue_req(REQ_RECORD, CLS_DATA,    8'hAA, 8'hFE, 9'd0);
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd252);   // short gap as a single
    queue_req(REQ_REPORT, CLS_DATA,    8'h00, 8'h00, 9'd253);
    drain();

    // random phases over several mask settings, extremes included
    write_mask(8'hFF);
    queue_random(PHASE_REQS);
    drain();
    write_mask(8'h00);
    queue_random(PHASE_REQS);
    drain();
    write_mask(8'($urandom_range(1, 254)));
    queue_random(PHASE_REQS);
    drain();
    write_mask(8'h01);
    queue_random(PHASE_REQS);
    drain();

    // last phase runs flat out on both sides
    write_mask(8'h80);
    calm = 1'b1;
    queue_random(PHASE_REQS);
    drain();

    if (tracked_results.size() != 0) failures++;
    if (failures == 0) begin
      $display("** packet_id_gap_tracker_unit: PASSED **");
    end else begin
      $display("** packet_id_gap_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/pgt_pkg.sv
design/pgt_front.sv
design/pgt_back.sv
design/pgt_res_fifo.sv
design/packet_id_gap_tracker_unit.sv
tb/packet_id_gap_tracker_unit_tb.sv
